@@ rtl/core/ppc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pkg
// Types and constants shared by the preset PD position controller core.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgPresetLow   = 3'd0,
    CfgPresetMid   = 3'd1,
    CfgPresetHigh  = 3'd2,
    CfgPropGain    = 3'd3,
    CfgDerivGain   = 3'd4,
    CfgStopMargin  = 3'd5,
    CfgTimeout     = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [15:0] PropGainRst   = 16'd92;
  localparam logic [15:0] DerivGainRst  = 16'd563;
  localparam logic [11:0] StopMarginRst = 12'd10;
  localparam logic [11:0] TimeoutRst    = 12'd150;

  // Hold power per preset
  localparam logic signed [7:0] HoldLow  = -8'sd10;
  localparam logic signed [7:0] HoldMid  = 8'sd6;
  localparam logic signed [7:0] HoldHigh = 8'sd9;

  localparam logic signed [7:0] PowerLimit = 8'sd127;

  // Preset index limits
  localparam logic [1:0] SelMin = 2'd0;
  localparam logic [1:0] SelMax = 2'd2;

  // Mode codes on the result word
  localparam logic [2:0] ModeIdle   = 3'd0;
  localparam logic [2:0] ModeHold   = 3'd1;
  localparam logic [2:0] ModeRaise  = 3'd2;
  localparam logic [2:0] ModeLower  = 3'd3;
  localparam logic [2:0] ModeSettle = 3'd4;

  // Controller state, one-hot
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StHold   = 5'b00010,
    StRaise  = 5'b00100,
    StLower  = 5'b01000,
    StSettle = 5'b10000
  } ctrl_st_e;

  typedef struct packed {
    logic [11:0] preset_low;
    logic [11:0] preset_mid;
    logic [11:0] preset_high;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [11:0] stop_margin;
    logic [11:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [11:0] pot_sample;
    logic        button_up;
    logic        button_down;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] motor_power;
    logic [2:0]        mode;
    logic [1:0]        preset_index;
  } out_word_t;

  // Result-word mode code for a controller state
  function automatic logic [2:0] mode_code(ctrl_st_e st);
    logic [2:0] code;
    case (st)
      StIdle:   code = ModeIdle;
      StHold:   code = ModeHold;
      StRaise:  code = ModeRaise;
      StLower:  code = ModeLower;
      StSettle: code = ModeSettle;
      default:  code = ModeIdle;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/ppc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_in_if / ppc_out_if
// Valid/ready channels carrying sample words in and result words out.
// ----------------------------------------------------------------------------
interface ppc_in_if;
  logic              valid;
  logic              ready;
  ppc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppc_out_if;
  logic               valid;
  logic               ready;
  ppc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ppc_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_cfg_regs
// Configuration register file; writes outside the list are dropped.
// ----------------------------------------------------------------------------
module ppc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_idx_i,
  input  wire logic [ppc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ppc_pkg::cfg_t                     cfg_o
);
  import ppc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPresetLow:  cfg_d.preset_low    = cfg_wdata_i[11:0];
        CfgPresetMid:  cfg_d.preset_mid    = cfg_wdata_i[11:0];
        CfgPresetHigh: cfg_d.preset_high   = cfg_wdata_i[11:0];
        CfgPropGain:   cfg_d.prop_gain     = cfg_wdata_i;
        CfgDerivGain:  cfg_d.deriv_gain    = cfg_wdata_i;
        CfgStopMargin: cfg_d.stop_margin   = cfg_wdata_i[11:0];
        CfgTimeout:    cfg_d.timeout_ticks = cfg_wdata_i[11:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preset_low    <= '0;
      cfg_q.preset_mid    <= '0;
      cfg_q.preset_high   <= '0;
      cfg_q.prop_gain     <= PropGainRst;
      cfg_q.deriv_gain    <= DerivGainRst;
      cfg_q.stop_margin   <= StopMarginRst;
      cfg_q.timeout_ticks <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/ppc_pd_drive.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_pd_drive
// PD power: (err*Kp + derr*Kd) / 1024 toward zero, clamped to +-127.
// ----------------------------------------------------------------------------
module ppc_pd_drive (
  input  wire logic signed [12:0] err_i,
  input  wire logic signed [12:0] prior_err_i,
  input  wire logic               first_i,
  input  wire logic [15:0]        prop_gain_i,
  input  wire logic [15:0]        deriv_gain_i,
  output logic signed [7:0]       power_o
);
  import ppc_pkg::*;

  logic signed [13:0] derr;
  logic signed [16:0] kp_s, kd_s;
  logic signed [31:0] prod_p, prod_d, sum, sum_adj;
  logic signed [21:0] quot;

  // Derivative term is zero on the first drive tick
  assign derr = first_i ? 14'sd0 : (14'(err_i) - 14'(prior_err_i));
  assign kp_s = $signed({1'b0, prop_gain_i});
  assign kd_s = $signed({1'b0, deriv_gain_i});

  // Two independent products and their sum
  assign prod_p = 32'(err_i) * 32'(kp_s);
  assign prod_d = 32'(derr) * 32'(kd_s);
  assign sum    = prod_p + prod_d;

  // Divide by 1024 truncating toward zero
  assign sum_adj = sum[31] ? (sum + 32'sd1023) : sum;
  assign quot    = 22'(sum_adj >>> 10);

  // Clamp
  always_comb begin
    if (quot > 22'(PowerLimit)) begin
      power_o = PowerLimit;
    end else if (quot < -22'(PowerLimit)) begin
      power_o = -PowerLimit;
    end else begin
      power_o = quot[7:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ppc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_step
// Controller state, per-tick update and the result register.
// ----------------------------------------------------------------------------
module ppc_step #(
  parameter int unsigned SETTLE_TICKS = 40,
  parameter int unsigned SENSOR_BITS  = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire ppc_pkg::in_word_t word_i,
  input  wire ppc_pkg::cfg_t     cfg_i,
  output ppc_pkg::out_word_t     res_o
);
  import ppc_pkg::*;

  localparam logic [11:0] SensorMask =
    (SENSOR_BITS >= 12) ? 12'hFFF : 12'((32'd1 << SENSOR_BITS) - 32'd1);
  localparam logic [11:0] SettleLim = 12'(SETTLE_TICKS);

  ctrl_st_e           st_q, st_d, st_a;
  logic [1:0]         sel_q, sel_d;
  logic [11:0]        tgt_q, tgt_d;
  logic signed [7:0]  hold_q, hold_d;
  logic [11:0]        el_q, el_d, el_a;
  logic signed [12:0] prior_q, prior_d, prior_a;
  logic               first_q, first_d, first_a;
  logic               prev_up_q, prev_dn_q;
  out_word_t          res_q, res_d;

  logic [11:0]        pos, new_tgt;
  logic signed [7:0]  new_hold;
  logic               rise_up, rise_dn, go;
  logic signed [13:0] pos_s, tgt_s, mrg_s;
  logic signed [12:0] err;
  logic signed [7:0]  pd_power;

  assign pos     = word_i.pot_sample & SensorMask;
  assign rise_up = word_i.button_up & ~prev_up_q;
  assign rise_dn = word_i.button_down & ~prev_dn_q;

  // Error against the target in force this tick; fresh when a move starts
  assign tgt_s = $signed({2'b00, tgt_d});
  assign pos_s = $signed({2'b00, pos});
  assign mrg_s = $signed({2'b00, cfg_i.stop_margin});
  assign err   = 13'(tgt_s - pos_s);

  ppc_pd_drive u_pd_drive (
    .err_i        (err),
    .prior_err_i  (prior_a),
    .first_i      (first_a),
    .prop_gain_i  (cfg_i.prop_gain),
    .deriv_gain_i (cfg_i.deriv_gain),
    .power_o      (pd_power)
  );

  // Per-tick update, first part: settle, then buttons
  always_comb begin
    st_a     = st_q;
    sel_d    = sel_q;
    tgt_d    = tgt_q;
    hold_d   = hold_q;
    el_a     = el_q;
    prior_a  = prior_q;
    first_a  = first_q;
    new_tgt  = cfg_i.preset_high;
    new_hold = HoldHigh;

    // Settling count, up to the limit
    if (st_a == StSettle) begin
      if (el_a >= SettleLim) begin
        st_a = StHold;
      end else begin
        el_a = el_a + 12'd1;
      end
    end

    // Button edges step the preset and may start a move
    if (st_a == StIdle || st_a == StHold) begin
      if (rise_up) begin
        if (sel_d < SelMax) sel_d = sel_d + 2'd1;
      end else if (rise_dn) begin
        if (sel_d > SelMin) sel_d = sel_d - 2'd1;
      end
      case (sel_d)
        2'd0: begin
          new_tgt  = cfg_i.preset_low;
          new_hold = HoldLow;
        end
        2'd1: begin
          new_tgt  = cfg_i.preset_mid;
          new_hold = HoldMid;
        end
        default: begin
          new_tgt  = cfg_i.preset_high;
          new_hold = HoldHigh;
        end
      endcase
      new_tgt = new_tgt & SensorMask;
      if ((rise_up || rise_dn) && pos != new_tgt) begin
        tgt_d   = new_tgt;
        hold_d  = new_hold;
        el_a    = '0;
        prior_a = '0;
        first_a = 1'b1;
        st_a    = (pos < new_tgt) ? StRaise : StLower;
      end
    end
  end

  // Per-tick update, second part: drive or end of move
  always_comb begin
    st_d    = st_a;
    el_d    = el_a;
    prior_d = prior_a;
    first_d = first_a;
    go      = 1'b0;
    res_d   = res_q;

    res_d.motor_power = hold_d;
    if (st_a == StRaise || st_a == StLower) begin
      // A move just started drives on this tick against the fresh target
      if (st_a == StRaise) begin
        go = pos_s < (tgt_s - mrg_s);
      end else begin
        go = pos_s > (tgt_s + mrg_s);
      end
      if (go && el_a < cfg_i.timeout_ticks) begin
        res_d.motor_power = pd_power;
        prior_d = err;
        first_d = 1'b0;
        el_d    = el_a + 12'd1;
      end else begin
        st_d = StSettle;
        el_d = '0;
      end
    end else if (st_a == StIdle) begin
      res_d.motor_power = '0;
    end

    res_d.mode         = mode_code(st_d);
    res_d.preset_index = sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      sel_q     <= '0;
      tgt_q     <= '0;
      hold_q    <= '0;
      el_q      <= '0;
      prior_q   <= '0;
      first_q   <= 1'b1;
      prev_up_q <= 1'b0;
      prev_dn_q <= 1'b0;
    end else if (adv_i) begin
      st_q      <= st_d;
      sel_q     <= sel_d;
      tgt_q     <= tgt_d;
      hold_q    <= hold_d;
      el_q      <= el_d;
      prior_q   <= prior_d;
      first_q   <= first_d;
      prev_up_q <= word_i.button_up;
      prev_dn_q <= word_i.button_down;
    end
  end

  // Result register, payload only
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q))
    else $error("controller state not one-hot");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q != 2'd3)
    else $error("preset index out of range");

  a_settle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSettle) |-> (el_q <= SettleLim))
    else $error("settle count beyond limit");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> (res_q.motor_power != -8'sd128))
    else $error("motor power outside +-127");

  a_idle_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i |=> ((res_q.mode != ModeIdle) || (res_q.motor_power == 8'sd0)))
    else $error("power driven while idle");

endmodule
`default_nettype wire

@@ rtl/core/preset_pd_position_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted word moves from the input register to the result register when
// that slot is free or being taken, one word per cycle while results are
// taken; the whole tick update is one pass between the two, with the state
// held beside it. Reset clears controller state, the pipeline valids and the
// configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// preset_pd_position_controller_core
// Preset-stepping position controller with PD motor drive, one word per tick.
// ----------------------------------------------------------------------------
module preset_pd_position_controller_core #(
  parameter int unsigned SETTLE_TICKS = 40,
  parameter int unsigned SENSOR_BITS  = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [2:0]                   cfg_idx_i,
  input  wire logic [ppc_pkg::CfgDataW-1:0] cfg_wdata_i,
  ppc_in_if.sink                            in_i,
  ppc_out_if.source                         res_o
);
  import ppc_pkg::*;

  cfg_t      cfg;
  in_word_t  s1_word_q;
  logic      s1_valid_q, res_valid_q;
  logic      adv;
  out_word_t res_word;

  ppc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance when the result slot is free or being taken
  assign adv        = s1_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_word_q <= in_i.data;
    end
  end

  ppc_step #(
    .SETTLE_TICKS (SETTLE_TICKS),
    .SENSOR_BITS  (SENSOR_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .word_i (s1_word_q),
    .cfg_i  (cfg),
    .res_o  (res_word)
  );

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_word;

endmodule
`default_nettype wire

@@ verif/preset_pd_position_controller_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preset_pd_position_controller_core_tb
// Self-checking bench for the preset PD position controller core. Sample
// words go in over valid/ready with bursty gaps and result words come out
// against a stalling sink. Each result word is checked field by field
// against an in-bench controller model that tracks state and registers.
// ----------------------------------------------------------------------------
module preset_pd_position_controller_core_tb;
  import ppc_pkg::*;

  localparam int unsigned SettleTicks   = 40;
  localparam int unsigned ResultLatency = 2;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned RandWords     = 1450;
  localparam int unsigned PhaseWords    = 240;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned MoveGuard     = 400;
  localparam int          SensorTop     = 4095;
  localparam logic [2:0]  CfgSpareIdx   = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [2:0]          cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  ppc_in_if  in_ch ();
  ppc_out_if res_ch ();

  preset_pd_position_controller_core #(
    .SETTLE_TICKS (SettleTicks),
    .SENSOR_BITS  (12)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .res_o       (res_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Controller model state and registers
  cfg_t              ctl_regs;
  logic [2:0]        ctl_mode;
  logic [1:0]        ctl_sel;
  logic [11:0]       ctl_target;
  logic signed [7:0] ctl_hold;
  logic [11:0]       ctl_elapsed;
  logic signed [12:0] ctl_prev_err;
  logic              ctl_first;
  logic              ctl_prev_up;
  logic              ctl_prev_dn;

  out_word_t   expected_words[$];
  out_word_t   want_w;
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned words_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned idle_cycles  = 0;
  int          plant_pos    = 0;
  logic [15:0] stall_pat;
  logic [3:0]  stall_phase;

  function automatic void reset_model();
    ctl_regs.preset_low    = '0;
    ctl_regs.preset_mid    = '0;
    ctl_regs.preset_high   = '0;
    ctl_regs.prop_gain     = PropGainRst;
    ctl_regs.deriv_gain    = DerivGainRst;
    ctl_regs.stop_margin   = StopMarginRst;
    ctl_regs.timeout_ticks = TimeoutRst;
    ctl_mode     = ModeIdle;
    ctl_sel      = SelMin;
    ctl_target   = '0;
    ctl_hold     = '0;
    ctl_elapsed  = '0;
    ctl_prev_err = '0;
    ctl_first    = 1'b1;
    ctl_prev_up  = 1'b0;
    ctl_prev_dn  = 1'b0;
  endfunction

  // Register write as the block sees it; narrow registers drop upper bits
  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      CfgPresetLow:  ctl_regs.preset_low    = data[11:0];
      CfgPresetMid:  ctl_regs.preset_mid    = data[11:0];
      CfgPresetHigh: ctl_regs.preset_high   = data[11:0];
      CfgPropGain:   ctl_regs.prop_gain     = data;
      CfgDerivGain:  ctl_regs.deriv_gain    = data;
      CfgStopMargin: ctl_regs.stop_margin   = data[11:0];
      CfgTimeout:    ctl_regs.timeout_ticks = data[11:0];
      default: ;
    endcase
  endfunction

  function automatic logic [11:0] preset_target(input logic [1:0] sel);
    logic [11:0] tgt;
    if (sel == SelMin) tgt = ctl_regs.preset_low;
    else if (sel == SelMax) tgt = ctl_regs.preset_high;
    else tgt = ctl_regs.preset_mid;
    return tgt;
  endfunction

  // One tick of the controller: returns the result word it produces
  function automatic out_word_t predict_tick(input in_word_t w);
    logic              rise_up;
    logic              rise_dn;
    logic [11:0]       tgt;
    logic signed [7:0] hp;
    logic signed [7:0] pwr;
    logic              go;
    int                pos;
    int                tgt_i;
    int                margin;
    int                err;
    longint            deriv;
    longint            sum;
    longint            quot;
    out_word_t         r;
    rise_up = w.button_up & ~ctl_prev_up;
    rise_dn = w.button_down & ~ctl_prev_dn;
    ctl_prev_up = w.button_up;
    ctl_prev_dn = w.button_down;
    pwr = '0;

    // settling runs out into holding
    if (ctl_mode == ModeSettle) begin
      if (ctl_elapsed >= SettleTicks) ctl_mode = ModeHold;
      else ctl_elapsed++;
    end

    // preset stepping and move start; up wins a tie
    if (ctl_mode == ModeIdle || ctl_mode == ModeHold) begin
      if (rise_up) begin
        if (ctl_sel < SelMax) ctl_sel++;
      end else if (rise_dn) begin
        if (ctl_sel > SelMin) ctl_sel--;
      end
      if (rise_up || rise_dn) begin
        tgt = preset_target(ctl_sel);
        if (ctl_sel == SelMin) hp = HoldLow;
        else if (ctl_sel == SelMax) hp = HoldHigh;
        else hp = HoldMid;
        if (w.pot_sample != tgt) begin
          ctl_target   = tgt;
          ctl_hold     = hp;
          ctl_elapsed  = '0;
          ctl_prev_err = '0;
          ctl_first    = 1'b1;
          ctl_mode     = (w.pot_sample < tgt) ? ModeRaise : ModeLower;
        end
      end
    end

    // PD drive, or the end of the move
    if (ctl_mode == ModeRaise || ctl_mode == ModeLower) begin
      pos    = w.pot_sample;
      tgt_i  = ctl_target;
      margin = ctl_regs.stop_margin;
      go = (ctl_mode == ModeRaise) ? (pos < tgt_i - margin) : (pos > tgt_i + margin);
      if (go && ctl_elapsed < ctl_regs.timeout_ticks) begin
        err   = tgt_i - pos;
        deriv = ctl_first ? 64'sd0 : longint'(err) - longint'(ctl_prev_err);
        sum   = longint'(err) * longint'(ctl_regs.prop_gain) +
                deriv * longint'(ctl_regs.deriv_gain);
        quot  = sum / 1024;
        if (quot > longint'(PowerLimit)) quot = longint'(PowerLimit);
        if (quot < -longint'(PowerLimit)) quot = -longint'(PowerLimit);
        pwr          = 8'(quot);
        ctl_prev_err = 13'(err);
        ctl_first    = 1'b0;
        ctl_elapsed++;
      end else begin
        pwr         = ctl_hold;
        ctl_mode    = ModeSettle;
        ctl_elapsed = '0;
      end
    end else if (ctl_mode == ModeIdle) begin
      pwr = '0;
    end else begin
      pwr = ctl_hold;
    end

    r.motor_power  = pwr;
    r.mode         = ctl_mode;
    r.preset_index = ctl_sel;
    return r;
  endfunction

  // Result checker: oldest expectation against each accepted word
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        if (mismatch_cnt < MaxReports)
          $display("result word %0d arrived with nothing expected: %h",
                   results_seen, res_ch.data);
        mismatch_cnt++;
      end else begin
        want_w = expected_words.pop_front();
        if (want_w.motor_power !== res_ch.data.motor_power ||
            want_w.mode !== res_ch.data.mode ||
            want_w.preset_index !== res_ch.data.preset_index) begin
          if (mismatch_cnt < MaxReports)
            $display("word %0d: power exp %0d got %0d, mode exp %0d got %0d, index exp %0d got %0d",
                     results_seen, want_w.motor_power, res_ch.data.motor_power,
                     want_w.mode, res_ch.data.mode,
                     want_w.preset_index, res_ch.data.preset_index);
          mismatch_cnt++;
        end
      end
    end
  end

  // Sink stalls: a fresh 16-bit ready pattern each round
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_phase  <= '0;
    end else begin
      if (stall_phase == 4'd0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hFFFF;
          1:       stall_pat = 16'hFFFF ^ (16'h0001 << $urandom_range(1, 15));
          2:       stall_pat = 16'h0101;
          default: stall_pat = 16'($urandom) | 16'h0001;
        endcase
      end
      res_ch.ready <= stall_pat[stall_phase];
      stall_phase  <= stall_phase + 4'd1;
    end
  end

  // Watchdog on cycles without any handshake or register write
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("preset_pd_position_controller_core regression: fail");
      $finish;
    end
  end

  // Send one sample word; bursts of random length with random gaps
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_words.push_back(predict_tick(w));
    words_sent++;
    burst_left--;
  endtask

  task automatic tick(input logic [11:0] pot, input logic up, input logic dn);
    in_word_t w;
    w.pot_sample  = pot;
    w.button_up   = up;
    w.button_down = dn;
    send_word(w);
  endtask

  // Crude plant: the sample follows the drive direction with some jitter
  task automatic plant_tick(input logic up, input logic dn);
    if (ctl_mode == ModeRaise) plant_pos = plant_pos + int'($urandom_range(0, 80));
    else if (ctl_mode == ModeLower) plant_pos = plant_pos - int'($urandom_range(0, 80));
    plant_pos = plant_pos + int'($urandom_range(0, 4)) - 2;
    if (plant_pos < 0) plant_pos = 0;
    if (plant_pos > SensorTop) plant_pos = SensorTop;
    tick(12'(plant_pos), up, dn);
  endtask

  // Hold off input until every result word is back, then let the pipe empty
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (ResultLatency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [11:0] pick_pos();
    logic [11:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = 12'(SensorTop);
      default: v = 12'($urandom);
    endcase
    return v;
  endfunction

  // Presets all zero after reset: a zero sample steps the index but never moves
  task automatic test_preset_stepping();
    tick(12'd0, 1'b0, 1'b0);
    tick(12'd0, 1'b1, 1'b0);
    tick(12'd0, 1'b0, 1'b0);
    tick(12'd0, 1'b1, 1'b1);
    tick(12'd0, 1'b0, 1'b0);
    tick(12'd0, 1'b1, 1'b0);
    tick(12'd0, 1'b0, 1'b1);
    tick(12'd0, 1'b0, 1'b0);
    tick(12'd0, 1'b0, 1'b1);
    tick(12'd0, 1'b0, 1'b0);
    tick(12'd0, 1'b0, 1'b1);
  endtask

  // A raise to full scale, edges ignored mid-move, button held through settling
  task automatic test_move_and_settle();
    drain_results();
    write_reg(CfgPresetLow, 16'hF7D0);
    write_reg(CfgPresetMid, 16'h0FFF);
    write_reg(CfgPresetHigh, 16'hA000);
    tick(12'd0, 1'b1, 1'b0);
    tick(12'd100, 1'b1, 1'b0);
    tick(12'd3000, 1'b0, 1'b1);
    tick(12'd4090, 1'b0, 1'b0);
    while (ctl_mode == ModeSettle) tick(12'd4090, 1'b1, 1'b0);
    tick(12'd4090, 1'b1, 1'b0);
    tick(12'd4090, 1'b0, 1'b0);
  endtask

  // No drive ticks allowed: the move ends on its first tick
  task automatic test_zero_timeout();
    drain_results();
    write_reg(CfgTimeout, 16'h0000);
    tick(12'd4095, 1'b0, 1'b1);
    while (ctl_mode == ModeSettle) tick(12'd4095, 1'b0, 1'b0);
  endtask

  // Full-scale gains: clamp at both rails, derivative swinging negative
  task automatic test_extreme_gains();
    drain_results();
    write_reg(CfgPropGain, 16'hFFFF);
    write_reg(CfgDerivGain, 16'hFFFF);
    write_reg(CfgStopMargin, 16'hF000);
    write_reg(CfgTimeout, 16'h0FFF);
    write_reg(CfgSpareIdx, 16'hFFFF);
    tick(12'd0, 1'b1, 1'b0);
    tick(12'd4000, 1'b0, 1'b0);
    tick(12'd4094, 1'b0, 1'b0);
    tick(12'd4095, 1'b0, 1'b0);
    while (ctl_mode == ModeSettle) tick(12'd4095, 1'b0, 1'b0);
  endtask

  // New register set, some phases pinned to the extremes
  task automatic randomise_regs(input int unsigned phase);
    logic [15:0] pg;
    logic [15:0] dg;
    logic [11:0] sm;
    logic [11:0] tmo;
    case (phase % 6)
      0: begin
        pg = 16'hFFFF; dg = 16'hFFFF; sm = '0; tmo = 12'hFFF;
      end
      1: begin
        pg = '0; dg = '0; sm = 12'hFFF; tmo = 12'd1;
      end
      2: begin
        pg = 16'($urandom_range(0, 400)); dg = 16'($urandom_range(0, 2000));
        sm = 12'($urandom_range(0, 40)); tmo = '0;
      end
      default: begin
        pg = 16'($urandom_range(0, 400)); dg = 16'($urandom_range(0, 2000));
        sm = 12'($urandom_range(0, 40)); tmo = 12'($urandom_range(1, 200));
      end
    endcase
    write_reg(CfgPresetLow, {4'($urandom), pick_pos()});
    write_reg(CfgPresetMid, {4'($urandom), pick_pos()});
    write_reg(CfgPresetHigh, {4'($urandom), pick_pos()});
    write_reg(CfgPropGain, pg);
    write_reg(CfgDerivGain, dg);
    write_reg(CfgStopMargin, {4'($urandom), sm});
    write_reg(CfgTimeout, {4'($urandom), tmo});
    write_reg(CfgSpareIdx, 16'($urandom));
  endtask

  // Release, press, optional hold, then ride the move out to holding
  task automatic move_episode();
    logic        up;
    logic        dn;
    logic [1:0]  next_sel;
    int unsigned guard;
    plant_tick(1'b0, 1'b0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin up = 1'b1; dn = 1'b0; end
      5, 6, 7, 8:    begin up = 1'b0; dn = 1'b1; end
      default:       begin up = 1'b1; dn = 1'b1; end
    endcase
    if (up) next_sel = (ctl_sel < SelMax) ? ctl_sel + 2'd1 : ctl_sel;
    else next_sel = (ctl_sel > SelMin) ? ctl_sel - 2'd1 : ctl_sel;
    // now and then sit exactly on the new target
    if ($urandom_range(0, 9) == 0) plant_pos = preset_target(next_sel);
    plant_tick(up, dn);
    repeat ($urandom_range(0, 3)) plant_tick(up, dn);
    guard = 0;
    while ((ctl_mode == ModeRaise || ctl_mode == ModeLower || ctl_mode == ModeSettle) &&
           guard < MoveGuard) begin
      if ($urandom_range(0, 15) == 0) plant_tick(1'($urandom), 1'($urandom));
      else plant_tick(1'b0, 1'b0);
      guard++;
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1) == 0) plant_pos = $urandom_range(0, SensorTop);
      tick(12'(plant_pos), 1'($urandom), 1'($urandom));
    end
  endtask

  // Random phases; the sender drains fully before every new register set
  task automatic test_random_ticks();
    int unsigned start;
    int unsigned phase_start;
    int unsigned phase;
    start = words_sent;
    phase = 0;
    plant_pos = SensorTop;
    while (words_sent - start < RandWords) begin
      drain_results();
      randomise_regs(phase);
      phase_start = words_sent;
      while (words_sent - phase_start < PhaseWords && words_sent - start < RandWords) begin
        if ($urandom_range(0, 4) != 0) move_episode();
        else noise_burst();
      end
      phase++;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgPresetLow;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    res_ch.ready = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_preset_stepping();
    test_move_and_settle();
    test_zero_timeout();
    test_extreme_gains();
    test_random_ticks();
    drain_results();

    if (mismatch_cnt == 0 && expected_words.size() == 0)
      $display("preset_pd_position_controller_core regression: pass");
    else
      $display("preset_pd_position_controller_core regression: fail");
    $finish;
  end

endmodule

@@ preset_pd_position_controller_core.f @@
rtl/core/ppc_pkg.sv
rtl/core/ppc_if.sv
rtl/core/ppc_cfg_regs.sv
rtl/core/ppc_pd_drive.sv
rtl/core/ppc_step.sv
rtl/core/preset_pd_position_controller_core.sv
verif/preset_pd_position_controller_core_tb.sv
